>>> rtl/core/lda_gs_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and helpers for the collapsed Gibbs topic sampler.
package lda_gs_pkg;

  localparam int COUNT_W     = 17;
  localparam int ALPHA_W     = 24;
  localparam int TOPICS_CFG_W = 7;
  localparam int VOCAB_CFG_W = 13;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int WEIGHT_W    = 48;
  localparam int TOPIC_W     = 6;
  localparam int INST_W      = 16;
  localparam int WORD_W      = 12;
  localparam int DOC_W       = 10;
  localparam int OP_W        = 2;
  localparam int UNIFORM_W   = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [TOPICS_CFG_W-1:0] TOPICS_RST = 7'd64;
  localparam logic [VOCAB_CFG_W-1:0]  VOCAB_RST  = 13'd4096;
  localparam logic [ALPHA_W-1:0]      ETA_RST    = 24'd655;

  localparam logic [CFG_IDX_W-1:0] CFG_TOPICS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOCAB  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA    = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_ALPHA = 2'd0,
    OP_ADD_INIT   = 2'd1,
    OP_RESAMPLE   = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_DEC_RD,
    ST_DEC_WR,
    ST_WALK,
    ST_DRAIN,
    ST_THR_MUL,
    ST_THR_ADD,
    ST_SCAN,
    ST_INC_RD,
    ST_INC_WR
  } state_t;

  function automatic logic [COUNT_W-1:0] cnt_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [COUNT_W-1:0] cnt_dec(input logic [COUNT_W-1:0] c);
    return (c == '0) ? c : c - 1'b1;
  endfunction

endpackage

>>> rtl/core/topic_model_collapsed_gibbs_step_core.sv
`timescale 1ns / 1ps
// Collapsed Gibbs topic sampler: count memories, weight pipeline, draw and update.
//
// Usage: pulse start with a command on the in_ ports while busy is low; the
// transaction is taken at that edge and busy rises. Exactly one result comes
// back on out_topic_out / out_error, flagged by a one-cycle out_valid; the
// receiver cannot stall it. cfg_we writes a register; the user must assert it only
// while busy is low (or during the clearing pass); the block does not enforce this.
// A resample walks all T topics through the count memories one per cycle, each
// weight passing the operand, split-multiply and product-sum registers and a
// 48-stage restoring divider, then scans the stored weights up to the sampled topic.
// One command is in flight at a time.
// Reset: configuration returns to T = 64, V = 4096, eta = 655; then a clearing
// pass zeroes the count and alpha memories, one address per cycle, across all
// 2^(log2(MAX_TOPICS) + log2(max(MAX_VOCAB, MAX_DOCS))) addresses with busy high.
// Instance topics are not cleared.
module topic_model_collapsed_gibbs_step_core #(
  parameter int MAX_TOPICS    = 64,
  parameter int MAX_VOCAB     = 4096,
  parameter int MAX_DOCS      = 1024,
  parameter int MAX_INSTANCES = 65536,
  parameter int FRAC_BITS     = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [lda_gs_pkg::OP_W-1:0]         in_op,
  input  logic [lda_gs_pkg::INST_W-1:0]       in_instance_req,
  input  logic [lda_gs_pkg::WORD_W-1:0]       in_word,
  input  logic [lda_gs_pkg::DOC_W-1:0]        in_doc,
  input  logic [lda_gs_pkg::TOPIC_W-1:0]      in_topic_in,
  input  logic [lda_gs_pkg::ALPHA_W-1:0]      in_alpha_value,
  input  logic [lda_gs_pkg::UNIFORM_W-1:0]    in_uniform,
  output logic                                out_valid,
  output logic [lda_gs_pkg::TOPIC_W-1:0]      out_topic_out,
  output logic                                out_error,
  input  logic                                cfg_we,
  input  logic [lda_gs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lda_gs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lda_gs_pkg::*;

  localparam int TW   = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1;
  localparam int TUW  = $clog2(MAX_TOPICS + 1);
  localparam int VW   = (MAX_VOCAB > 1) ? $clog2(MAX_VOCAB) : 1;
  localparam int DW   = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
  localparam int IW   = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
  localparam int CLRW = TW + ((VW > DW) ? VW : DW);
  localparam int SHW  = COUNT_W + FRAC_BITS;
  localparam int AW   = ((SHW > ALPHA_W) ? SHW : ALPHA_W) + 1;
  localparam int VEW  = VOCAB_CFG_W + ALPHA_W;
  localparam int DDW  = ((SHW > VEW) ? SHW : VEW) + 1;
  localparam int H    = (AW + 1) / 2;
  localparam int PPW  = 2 * H;
  localparam int PW   = 2 * AW;
  localparam int NDIV = WEIGHT_W;
  localparam int SW   = WEIGHT_W + TUW;

  // configuration
  logic [TOPICS_CFG_W-1:0] cfg_topics_r;
  logic [VOCAB_CFG_W-1:0]  cfg_vocab_r;
  logic [ALPHA_W-1:0]      cfg_eta_r;
  logic [TUW-1:0]          t_use;

  state_t state_r, state_nxt;
  logic   accept;

  // latched command
  logic [OP_W-1:0]      op_r;
  logic [IW-1:0]        inst_r;
  logic [VW-1:0]        word_r;
  logic [DW-1:0]        doc_r;
  logic [TOPIC_W-1:0]   tin_r;
  logic [ALPHA_W-1:0]   alpha_r;
  logic [UNIFORM_W-1:0] u_r;
  logic                 bad_r;
  logic                 tin_ok;

  logic [TW-1:0]   sel_r;
  logic [TW-1:0]   k_r;
  logic [TUW-1:0]  wk_r;
  logic [TUW-1:0]  si_r;
  logic [TW-1:0]   sidx_r;
  logic            sv_r;
  logic [CLRW-1:0] clr_r;

  logic [SW-1:0] total_r, ph_r, thr_r, cum_r, cum_sum;
  logic [63:0]   pl_r;
  logic          hit, sidx_last;

  logic                 out_valid_r, out_valid_nxt;
  logic [TOPIC_W-1:0]   out_topic_r, out_topic_nxt;
  logic                 out_error_r, out_error_nxt;

  // memories
  logic [COUNT_W-1:0]  wt_mem  [1 << (TW + VW)];
  logic [COUNT_W-1:0]  dt_mem  [1 << (TW + DW)];
  logic [COUNT_W-1:0]  tot_mem [1 << TW];
  logic [ALPHA_W-1:0]  al_mem  [1 << TW];
  logic [TW-1:0]       ins_mem [1 << IW];
  logic [WEIGHT_W-1:0] w_mem   [1 << TW];

  logic [COUNT_W-1:0]  wt_q_r, dt_q_r, tot_q_r;
  logic [ALPHA_W-1:0]  al_q_r;
  logic [TW-1:0]       inst_q_r;
  logic [WEIGHT_W-1:0] w_q_r;

  logic                cnt_we, al_we, inst_we, clearing;
  logic [TW-1:0]       rd_topic;
  logic [TW+VW-1:0]    wt_wa, wt_ra;
  logic [TW+DW-1:0]    dt_wa, dt_ra;
  logic [TW-1:0]       tot_wa, al_wa;
  logic [COUNT_W-1:0]  wt_wd, dt_wd, tot_wd;
  logic [ALPHA_W-1:0]  al_wd;

  // weight pipeline
  logic           v1_r, va_r, vb_r, vc_r;
  logic [AW-1:0]  a_r, b_r;
  logic [DDW-1:0] d_r, db_r, dc_r;
  logic [VEW-1:0] veta_r;
  logic [PPW-1:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [PW-1:0]  p_r;

  logic [DDW-1:0]      rem_s [NDIV+1];
  logic [DDW-1:0]      dv_s  [NDIV+1];
  logic [WEIGHT_W-1:0] qd_s  [NDIV+1];
  logic                fz_s  [NDIV+1];
  logic                fs_s  [NDIV+1];
  logic                v_s   [NDIV+1];
  logic [WEIGHT_W-1:0] w_fin;

  assign busy          = (state_r != ST_IDLE);
  assign accept        = start && !busy;
  assign out_valid     = out_valid_r;
  assign out_topic_out = out_topic_r;
  assign out_error     = out_error_r;

  always_comb begin
    if (cfg_topics_r == '0) begin
      t_use = TUW'(1);
    end else if (32'(cfg_topics_r) > MAX_TOPICS) begin
      t_use = TUW'(MAX_TOPICS);
    end else begin
      t_use = TUW'(cfg_topics_r);
    end
  end

  assign tin_ok = (32'(tin_r) < 32'(t_use));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_topics_r <= TOPICS_RST;
      cfg_vocab_r  <= VOCAB_RST;
      cfg_eta_r    <= ETA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOPICS: cfg_topics_r <= cfg_wdata[TOPICS_CFG_W-1:0];
        CFG_VOCAB:  cfg_vocab_r  <= cfg_wdata[VOCAB_CFG_W-1:0];
        CFG_ETA:    cfg_eta_r    <= cfg_wdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      out_topic_r <= '0;
      out_error_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_topic_r <= out_topic_nxt;
      out_error_r <= out_error_nxt;
    end
  end

  assign cum_sum   = cum_r + SW'(w_q_r);
  assign hit       = (cum_sum >= thr_r);
  assign sidx_last = (TUW'(sidx_r) == t_use - 1'b1);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_topic_nxt = out_topic_r;
    out_error_nxt = out_error_r;
    cnt_we        = 1'b0;
    al_we         = 1'b0;
    inst_we       = 1'b0;
    rd_topic      = sel_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_we = 1'b1;
        al_we  = 1'b1;
        if (&clr_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (op_r)
          OP_LOAD_ALPHA: begin
            al_we         = tin_ok;
            out_valid_nxt = 1'b1;
            out_topic_nxt = tin_r;
            out_error_nxt = !tin_ok;
            state_nxt     = ST_IDLE;
          end
          OP_ADD_INIT: begin
            if (tin_ok && !bad_r) begin
              state_nxt = ST_INC_RD;
            end else begin
              out_valid_nxt = 1'b1;
              out_topic_nxt = tin_r;
              out_error_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          OP_RESAMPLE: begin
            if (!bad_r) begin
              state_nxt = ST_DEC_RD;
            end else begin
              out_valid_nxt = 1'b1;
              out_topic_nxt = '0;
              out_error_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_topic_nxt = '0;
            out_error_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        endcase
      end
      ST_DEC_RD: begin
        rd_topic  = inst_q_r;
        state_nxt = ST_DEC_WR;
      end
      ST_DEC_WR: begin
        cnt_we    = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        rd_topic = k_r;
        if (TUW'(k_r) == t_use - 1'b1) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (wk_r == t_use) state_nxt = ST_THR_MUL;
      end
      ST_THR_MUL: state_nxt = ST_THR_ADD;
      ST_THR_ADD: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sv_r && (hit || sidx_last)) state_nxt = ST_INC_RD;
      end
      ST_INC_RD: state_nxt = ST_INC_WR;
      ST_INC_WR: begin
        cnt_we        = 1'b1;
        inst_we       = 1'b1;
        out_valid_nxt = 1'b1;
        out_topic_nxt = TOPIC_W'(sel_r);
        out_error_nxt = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory address and data selection
  assign clearing = (state_r == ST_CLEAR);
  assign wt_ra    = {rd_topic, word_r};
  assign dt_ra    = {rd_topic, doc_r};
  assign wt_wa    = clearing ? clr_r[TW+VW-1:0] : {sel_r, word_r};
  assign dt_wa    = clearing ? clr_r[TW+DW-1:0] : {sel_r, doc_r};
  assign tot_wa   = clearing ? clr_r[TW-1:0] : sel_r;
  assign al_wa    = clearing ? clr_r[TW-1:0] : TW'(tin_r);
  assign al_wd    = clearing ? '0 : alpha_r;

  always_comb begin
    if (clearing) begin
      wt_wd  = '0;
      dt_wd  = '0;
      tot_wd = '0;
    end else if (state_r == ST_INC_WR) begin
      wt_wd  = cnt_inc(wt_q_r);
      dt_wd  = cnt_inc(dt_q_r);
      tot_wd = cnt_inc(tot_q_r);
    end else begin
      wt_wd  = cnt_dec(wt_q_r);
      dt_wd  = cnt_dec(dt_q_r);
      tot_wd = cnt_dec(tot_q_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) wt_mem[wt_wa] <= wt_wd;
    wt_q_r <= wt_mem[wt_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) dt_mem[dt_wa] <= dt_wd;
    dt_q_r <= dt_mem[dt_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) tot_mem[tot_wa] <= tot_wd;
    tot_q_r <= tot_mem[rd_topic];
  end

  always_ff @(posedge clk) begin
    if (al_we) al_mem[al_wa] <= al_wd;
    al_q_r <= al_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (inst_we) ins_mem[inst_r] <= sel_r;
    inst_q_r <= ins_mem[inst_r];
  end

  always_ff @(posedge clk) begin
    if (v_s[NDIV]) w_mem[TW'(wk_r)] <= w_fin;
    w_q_r <= w_mem[TW'(si_r)];
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      k_r   <= '0;
      wk_r  <= '0;
      si_r  <= '0;
      sv_r  <= 1'b0;
      v1_r  <= 1'b0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      vc_r  <= 1'b0;
    end else begin
      if (clearing) clr_r <= clr_r + 1'b1;
      v1_r <= (state_r == ST_WALK);
      va_r <= v1_r;
      vb_r <= va_r;
      vc_r <= vb_r;
      sv_r <= (state_r == ST_SCAN) && (si_r < t_use);
      if (state_r == ST_DEC_WR) begin
        k_r  <= '0;
        wk_r <= '0;
      end else begin
        if (state_r == ST_WALK) k_r <= k_r + 1'b1;
        if (v_s[NDIV]) wk_r <= wk_r + 1'b1;
      end
      if (state_r == ST_THR_ADD) si_r <= '0;
      else if (state_r == ST_SCAN) si_r <= si_r + 1'b1;
    end
  end

  // command capture and draw datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      inst_r  <= IW'(in_instance_req);
      word_r  <= VW'(in_word);
      doc_r   <= DW'(in_doc);
      tin_r   <= in_topic_in;
      alpha_r <= in_alpha_value;
      u_r     <= in_uniform;
      bad_r   <= (VOCAB_CFG_W'(in_word) >= cfg_vocab_r) || (32'(in_word) >= MAX_VOCAB) ||
                 (32'(in_doc) >= MAX_DOCS) || (32'(in_instance_req) >= MAX_INSTANCES);
    end
    case (state_r)
      ST_DECODE: sel_r <= TW'(tin_r);
      ST_DEC_RD: sel_r <= inst_q_r;
      ST_SCAN: begin
        if (sv_r) begin
          cum_r <= cum_sum;
          if (hit) sel_r <= sidx_r;
          else if (sidx_last) sel_r <= '0;
        end
      end
      default: ;
    endcase
    if (state_r == ST_DEC_WR) total_r <= '0;
    else if (v_s[NDIV]) total_r <= total_r + SW'(w_fin);
    ph_r   <= SW'(total_r[SW-1:32]) * SW'(u_r);
    pl_r   <= 64'(total_r[31:0]) * 64'(u_r);
    if (state_r == ST_THR_ADD) begin
      thr_r <= ph_r + SW'(pl_r[63:32]);
      cum_r <= '0;
    end
    sidx_r <= TW'(si_r);
  end

  // weight pipeline: operands, split multiply, product sum
  always_ff @(posedge clk) begin
    veta_r <= VEW'(cfg_vocab_r) * VEW'(cfg_eta_r);
    a_r    <= (AW'(dt_q_r) << FRAC_BITS) + AW'(al_q_r);
    b_r    <= (AW'(wt_q_r) << FRAC_BITS) + AW'(cfg_eta_r);
    d_r    <= (DDW'(tot_q_r) << FRAC_BITS) + DDW'(veta_r);
    pp00_r <= PPW'(a_r[H-1:0]) * PPW'(b_r[H-1:0]);
    pp01_r <= PPW'(a_r[H-1:0]) * PPW'(b_r[AW-1:H]);
    pp10_r <= PPW'(a_r[AW-1:H]) * PPW'(b_r[H-1:0]);
    pp11_r <= PPW'(a_r[AW-1:H]) * PPW'(b_r[AW-1:H]);
    db_r   <= d_r;
    p_r    <= (PW'(pp11_r) << (2 * H)) + ((PW'(pp01_r) + PW'(pp10_r)) << H) + PW'(pp00_r);
    dc_r   <= db_r;
    // quotient of 2^48 or more saturates; otherwise the high part seeds the remainder
    rem_s[0] <= DDW'(p_r >> WEIGHT_W);
    qd_s[0]  <= p_r[WEIGHT_W-1:0];
    dv_s[0]  <= dc_r;
    fz_s[0]  <= (dc_r == '0);
    fs_s[0]  <= ((p_r >> WEIGHT_W) >= PW'(dc_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_s[0] <= 1'b0;
    else        v_s[0] <= vc_r;
  end

  // restoring divider, one quotient bit per stage; qd shifts dividend out, quotient in
  for (genvar g = 0; g < NDIV; g++) begin : g_div
    logic [DDW:0] trial;
    logic         take;
    assign trial = {rem_s[g], qd_s[g][WEIGHT_W-1]};
    assign take  = (trial >= {1'b0, dv_s[g]});

    always_ff @(posedge clk) begin
      rem_s[g+1] <= take ? DDW'(trial - {1'b0, dv_s[g]}) : DDW'(trial);
      qd_s[g+1]  <= {qd_s[g][WEIGHT_W-2:0], take};
      dv_s[g+1]  <= dv_s[g];
      fz_s[g+1]  <= fz_s[g];
      fs_s[g+1]  <= fs_s[g];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_s[g+1] <= 1'b0;
      else        v_s[g+1] <= v_s[g];
    end
  end

  assign w_fin = fz_s[NDIV] ? '0 : (fs_s[NDIV] ? '1 : qd_s[NDIV]);

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accepted transaction");

  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_weight_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (wk_r <= t_use))
    else $error("more weights than topics in use");

  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INC_WR && op_r == OP_RESAMPLE) |-> (TUW'(sel_r) < t_use))
    else $error("sampled topic outside topics in use");

  a_no_walk_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !v_s[NDIV])
    else $error("weight still in flight during scan");

endmodule

>>> test/tb_topic_model_collapsed_gibbs_step_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the collapsed Gibbs topic sampler core.
module tb_topic_model_collapsed_gibbs_step_core;
  import lda_gs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int N_TOPICS = 64;
  localparam int N_VOCAB = 4096;
  localparam int N_DOCS = 1024;
  localparam int F_BITS = 16;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [127:0] W_SAT = 128'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [TOPIC_W-1:0] topic;
    logic               err;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] in_op = '0;
  logic [INST_W-1:0] in_instance_req = '0;
  logic [WORD_W-1:0] in_word = '0;
  logic [DOC_W-1:0] in_doc = '0;
  logic [TOPIC_W-1:0] in_topic_in = '0;
  logic [ALPHA_W-1:0] in_alpha_value = '0;
  logic [UNIFORM_W-1:0] in_uniform = '0;
  logic out_valid;
  logic [TOPIC_W-1:0] out_topic_out;
  logic out_error;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  topic_model_collapsed_gibbs_step_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_instance_req(in_instance_req), .in_word(in_word),
    .in_doc(in_doc), .in_topic_in(in_topic_in), .in_alpha_value(in_alpha_value),
    .in_uniform(in_uniform), .out_valid(out_valid), .out_topic_out(out_topic_out),
    .out_error(out_error), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // shadow state of the sampler
  logic [COUNT_W-1:0] word_cnt [int];
  logic [COUNT_W-1:0] doc_cnt [int];
  logic [COUNT_W-1:0] tot_cnt [int];
  logic [TOPIC_W-1:0] inst_topic [int];
  logic [ALPHA_W-1:0] alpha_tab [int];
  int unsigned assigned_insts [int];
  int n_assigned = 0;
  logic [6:0] cur_topics = TOPICS_RST;
  logic [12:0] cur_vocab = VOCAB_RST;
  logic [23:0] cur_eta = ETA_RST;

  // expected results in order, indexed by sequence number
  sample_t pending_exp [int];
  int pend_wr = 0;
  int pend_rd = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_resample = 0;
  int n_checked = 0;
  longint cycles = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic logic [COUNT_W-1:0] get_cnt(ref logic [COUNT_W-1:0] arr [int],
                                                 input int key);
    return arr.exists(key) ? arr[key] : '0;
  endfunction

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c, input bit up);
    if (up) return (c == COUNT_MAX) ? c : c + 1'b1;
    return (c == '0) ? c : c - 1'b1;
  endfunction

  function automatic int unsigned eff_topics();
    if (cur_topics == 0) return 1;
    if (cur_topics > N_TOPICS) return N_TOPICS;
    return cur_topics;
  endfunction

  function automatic void adjust_counts(input int t, input int w, input int d, input bit up);
    word_cnt[t*N_VOCAB + w] = bump(get_cnt(word_cnt, t*N_VOCAB + w), up);
    doc_cnt[t*N_DOCS + d] = bump(get_cnt(doc_cnt, t*N_DOCS + d), up);
    tot_cnt[t] = bump(get_cnt(tot_cnt, t), up);
  endfunction

  // expected result of one command, updating the shadow state
  function automatic sample_t gibbs_predict(input logic [OP_W-1:0] op, input int inst,
                                            input int w, input int d, input int tin,
                                            input logic [23:0] alpha,
                                            input logic [31:0] u);
    sample_t r;
    int unsigned tu;
    bit loc_bad;
    int old_t, pick;
    logic [127:0] a, b, dn, wk [N_TOPICS];
    logic [127:0] total, thr, cum;
    tu = eff_topics();
    loc_bad = (w >= cur_vocab) || (w >= N_VOCAB) || (d >= N_DOCS);
    r.topic = '0;
    r.err = 1'b1;
    if (op == OP_LOAD_ALPHA) begin
      r.topic = TOPIC_W'(tin);
      if (tin < tu) begin
        alpha_tab[tin] = alpha;
        r.err = 1'b0;
      end
    end else if (op == OP_ADD_INIT) begin
      r.topic = TOPIC_W'(tin);
      if (tin < tu && !loc_bad) begin
        if (!inst_topic.exists(inst)) begin
          assigned_insts[n_assigned] = inst;
          n_assigned++;
        end
        inst_topic[inst] = TOPIC_W'(tin);
        adjust_counts(tin, w, d, 1'b1);
        r.err = 1'b0;
      end
    end else if (op == OP_RESAMPLE && !loc_bad) begin
      old_t = inst_topic.exists(inst) ? inst_topic[inst] : 0;
      adjust_counts(old_t, w, d, 1'b0);
      total = '0;
      for (int k = 0; k < tu; k++) begin
        a = (128'(get_cnt(doc_cnt, k*N_DOCS + d)) << F_BITS) +
            (alpha_tab.exists(k) ? alpha_tab[k] : 24'd0);
        b = (128'(get_cnt(word_cnt, k*N_VOCAB + w)) << F_BITS) + cur_eta;
        dn = (128'(get_cnt(tot_cnt, k)) << F_BITS) + 128'(cur_vocab) * cur_eta;
        if (dn == 0) wk[k] = '0;
        else begin
          wk[k] = (a * b) / dn;
          if (wk[k] > W_SAT) wk[k] = W_SAT;
        end
        total += wk[k];
      end
      thr = (total * u) >> 32;
      cum = '0;
      pick = 0;
      for (int k = 0; k < tu; k++) begin
        cum += wk[k];
        if (cum >= thr) begin
          pick = k;
          break;
        end
      end
      inst_topic[inst] = TOPIC_W'(pick);
      adjust_counts(pick, w, d, 1'b1);
      r.topic = TOPIC_W'(pick);
      r.err = 1'b0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 0;
    if (sel < 75) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 150);
  endfunction

  // drive one command and wait until the core takes the transaction
  task automatic send_cmd(input logic [OP_W-1:0] op, input int inst, input int w,
                          input int d, input int tin, input logic [23:0] alpha,
                          input logic [31:0] u, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_instance_req <= INST_W'(inst);
    in_word <= WORD_W'(w);
    in_doc <= DOC_W'(d);
    in_topic_in <= TOPIC_W'(tin);
    in_alpha_value <= alpha;
    in_uniform <= u;
    do @(posedge clk); while (busy);
    pending_exp[pend_wr] = gibbs_predict(op, inst, w, d, tin, alpha, u);
    pend_wr++;
    n_sent++;
    if (op == OP_RESAMPLE) n_resample++;
  endtask

  task automatic drain_idle();
    start <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    drain_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TOPICS) cur_topics = val[6:0];
    else if (idx == CFG_VOCAB) cur_vocab = val[12:0];
    else if (idx == CFG_ETA) cur_eta = val;
  endtask

  task automatic set_config(input int t, input int v, input logic [23:0] e);
    write_cfg(CFG_TOPICS, 24'(t));
    write_cfg(CFG_VOCAB, 24'(v));
    write_cfg(CFG_ETA, e);
  endtask

  always @(posedge clk) begin
    sample_t exp_s;
    if (rst_n && out_valid) begin
      if (pend_wr == pend_rd) report("result with no command outstanding");
      else begin
        exp_s = pending_exp[pend_rd];
        pending_exp.delete(pend_rd);
        pend_rd++;
        n_checked++;
        if (out_topic_out !== exp_s.topic)
          report($sformatf("topic_out %0d, expected %0d", out_topic_out, exp_s.topic));
        if (out_error !== exp_s.err)
          report($sformatf("error %0b, expected %0b", out_error, exp_s.err));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // extremes at reset defaults and two further settings, every op, error paths
  task automatic test_directed();
    send_cmd(OP_LOAD_ALPHA, 0, 0, 0, 0, 24'h000000, 32'h0, 0);
    send_cmd(OP_LOAD_ALPHA, 0, 0, 0, 63, 24'hFFFFFF, 32'h0, 1);
    send_cmd(OP_LOAD_ALPHA, 0, 0, 0, 5, 24'h010000, 32'h0, 0);
    send_cmd(OP_UNUSED, 65535, 4095, 1023, 63, 24'hFFFFFF, 32'hFFFFFFFF, 2);
    send_cmd(OP_ADD_INIT, 0, 0, 0, 0, 24'h0, 32'h0, 0);
    send_cmd(OP_ADD_INIT, 65535, 4095, 1023, 63, 24'h0, 32'h0, 0);
    send_cmd(OP_ADD_INIT, 1, 0, 0, 5, 24'h0, 32'h0, 3);
    send_cmd(OP_RESAMPLE, 65535, 4095, 1023, 0, 24'h0, 32'h00000000, 0);
    send_cmd(OP_RESAMPLE, 65535, 4095, 1023, 0, 24'h0, 32'hFFFFFFFF, 0);
    send_cmd(OP_RESAMPLE, 0, 0, 0, 0, 24'h0, 32'h80000000, 5);
    // word differs from the stored one: decrement saturates at zero
    send_cmd(OP_RESAMPLE, 1, 17, 9, 0, 24'h0, 32'h12345678, 0);
    set_config(8, 16, 24'd1000);
    send_cmd(OP_LOAD_ALPHA, 0, 0, 0, 8, 24'h1234, 32'h0, 0);
    send_cmd(OP_ADD_INIT, 2, 16, 0, 1, 24'h0, 32'h0, 0);
    send_cmd(OP_ADD_INIT, 2, 3, 0, 9, 24'h0, 32'h0, 0);
    // stored topic 63 now above T: still removed from its own counts
    send_cmd(OP_RESAMPLE, 65535, 4095, 1023, 0, 24'h0, 32'h55555555, 0);
    send_cmd(OP_RESAMPLE, 65535, 15, 1023, 0, 24'h0, 32'hAAAAAAAA, 0);
    send_cmd(OP_RESAMPLE, 0, 0, 0, 0, 24'h0, 32'hFFFFFFFF, 0);
    // eta zero with zero totals: zero denominators
    set_config(0, 1, 24'd0);
    send_cmd(OP_RESAMPLE, 0, 0, 0, 0, 24'h0, 32'h40000000, 0);
    send_cmd(OP_ADD_INIT, 3, 0, 0, 1, 24'h0, 32'h0, 0);
    send_cmd(OP_ADD_INIT, 3, 0, 0, 0, 24'h0, 32'h0, 0);
  endtask

  task automatic random_item();
    int sel, tu, wl, w, d, inst, tin;
    sel = $urandom_range(0, 99);
    tu = eff_topics();
    wl = (cur_vocab < 16) ? ((cur_vocab == 0) ? 1 : cur_vocab) : 16;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, wl - 1);
    d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 7);
    tin = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, tu - 1);
    if (sel < 50 && n_assigned != 0) begin
      inst = assigned_insts[$urandom_range(0, n_assigned - 1)];
      send_cmd(OP_RESAMPLE, inst, w, d, $urandom_range(0, 63),
               24'($urandom_range(0, 24'hFFFFFF)), $urandom, pick_gap());
    end else if (sel < 82) begin
      inst = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 31);
      send_cmd(OP_ADD_INIT, inst, w, d, tin, 24'($urandom_range(0, 24'hFFFFFF)), $urandom,
               pick_gap());
    end else if (sel < 96) begin
      send_cmd(OP_LOAD_ALPHA, $urandom_range(0, 65535), w, d, tin,
               24'($urandom_range(0, 24'hFFFFFF)), $urandom, pick_gap());
    end else begin
      send_cmd(OP_UNUSED, $urandom_range(0, 65535), w, d, tin,
               24'($urandom_range(0, 24'hFFFFFF)), $urandom, pick_gap());
    end
  endtask

  task automatic test_random_phases();
    int t_set [8] = '{64, 1, 127, 0, 8, 3, 20, 64};
    int v_set [8] = '{4096, 1, 8191, 4096, 16, 4096, 64, 100};
    logic [23:0] e_set [8] = '{24'd655, 24'd0, 24'hFFFFFF, 24'd0, 24'd1000,
                               24'hFFFFFF, 24'd65536, 24'd655};
    for (int p = 0; p < 8; p++) begin
      set_config(t_set[p], v_set[p], e_set[p]);
      repeat (60) random_item();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // clearing pass after reset
    while (busy) @(posedge clk);
    test_directed();
    test_random_phases();
    drain_idle();
    repeat (300) @(posedge clk);
    $display("Covered %0d commands (%0d resamples) over 10 register settings, %0d checked.",
             n_sent, n_resample, n_checked);
    if (n_errors == 0 && pend_wr == pend_rd) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, pend_wr - pend_rd);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
